[rtl/core/sbpr_pkg.sv]
// Shared types, codes and the inverse S-box table for the bounded random generator.
`timescale 1ns / 1ps
`default_nettype none

package sbpr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned MAX_ATTEMPTS = 1024;
  localparam int unsigned ATTEMPT_W   = $clog2(MAX_ATTEMPTS);

  localparam logic [WORD_W-1:0] MASK_INIT = 16'hFFFF;

  // Command codes; the fourth code is unused and dropped.
  localparam logic [CMD_W-1:0] CMD_RESEED  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BOUNDED = 2'd2;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_RESEED = 7'b0000010,
    ST_BYTE   = 7'b0000100,
    ST_LO     = 7'b0001000,
    ST_HI     = 7'b0010000,
    ST_CHECK  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;          // latch the input fields
    logic start_bounded; // restart mask and attempt count
    logic reseed;        // run the reseed round
    logic round;         // run one generator round
    logic take_byte;     // result is the new third register
    logic take_lo;       // hold the low byte of the word
    logic take_hi;       // assemble the full word
    logic check;         // test the masked word against the bound
    logic emit;          // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;      // word accepted, or attempts used up
    logic out_busy; // output register holds a result that is not taken
  } dp_status_t;

  localparam logic [BYTE_W-1:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6A, 8'hD5, 8'h30, 8'h36, 8'hA5, 8'h38,
    8'hBF, 8'h40, 8'hA3, 8'h9E, 8'h81, 8'hF3, 8'hD7, 8'hFB,
    8'h7C, 8'hE3, 8'h39, 8'h82, 8'h9B, 8'h2F, 8'hFF, 8'h87,
    8'h34, 8'h8E, 8'h43, 8'h44, 8'hC4, 8'hDE, 8'hE9, 8'hCB,
    8'h54, 8'h7B, 8'h94, 8'h32, 8'hA6, 8'hC2, 8'h23, 8'h3D,
    8'hEE, 8'h4C, 8'h95, 8'h0B, 8'h42, 8'hFA, 8'hC3, 8'h4E,
    8'h08, 8'h2E, 8'hA1, 8'h66, 8'h28, 8'hD9, 8'h24, 8'hB2,
    8'h76, 8'h5B, 8'hA2, 8'h49, 8'h6D, 8'h8B, 8'hD1, 8'h25,
    8'h72, 8'hF8, 8'hF6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hD4, 8'hA4, 8'h5C, 8'hCC, 8'h5D, 8'h65, 8'hB6, 8'h92,
    8'h6C, 8'h70, 8'h48, 8'h50, 8'hFD, 8'hED, 8'hB9, 8'hDA,
    8'h5E, 8'h15, 8'h46, 8'h57, 8'hA7, 8'h8D, 8'h9D, 8'h84,
    8'h90, 8'hD8, 8'hAB, 8'h00, 8'h8C, 8'hBC, 8'hD3, 8'h0A,
    8'hF7, 8'hE4, 8'h58, 8'h05, 8'hB8, 8'hB3, 8'h45, 8'h06,
    8'hD0, 8'h2C, 8'h1E, 8'h8F, 8'hCA, 8'h3F, 8'h0F, 8'h02,
    8'hC1, 8'hAF, 8'hBD, 8'h03, 8'h01, 8'h13, 8'h8A, 8'h6B,
    8'h3A, 8'h91, 8'h11, 8'h41, 8'h4F, 8'h67, 8'hDC, 8'hEA,
    8'h97, 8'hF2, 8'hCF, 8'hCE, 8'hF0, 8'hB4, 8'hE6, 8'h73,
    8'h96, 8'hAC, 8'h74, 8'h22, 8'hE7, 8'hAD, 8'h35, 8'h85,
    8'hE2, 8'hF9, 8'h37, 8'hE8, 8'h1C, 8'h75, 8'hDF, 8'h6E,
    8'h47, 8'hF1, 8'h1A, 8'h71, 8'h1D, 8'h29, 8'hC5, 8'h89,
    8'h6F, 8'hB7, 8'h62, 8'h0E, 8'hAA, 8'h18, 8'hBE, 8'h1B,
    8'hFC, 8'h56, 8'h3E, 8'h4B, 8'hC6, 8'hD2, 8'h79, 8'h20,
    8'h9A, 8'hDB, 8'hC0, 8'hFE, 8'h78, 8'hCD, 8'h5A, 8'hF4,
    8'h1F, 8'hDD, 8'hA8, 8'h33, 8'h88, 8'h07, 8'hC7, 8'h31,
    8'hB1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hEC, 8'h5F,
    8'h60, 8'h51, 8'h7F, 8'hA9, 8'h19, 8'hB5, 8'h4A, 8'h0D,
    8'h2D, 8'hE5, 8'h7A, 8'h9F, 8'h93, 8'hC9, 8'h9C, 8'hEF,
    8'hA0, 8'hE0, 8'h3B, 8'h4D, 8'hAE, 8'h2A, 8'hF5, 8'hB0,
    8'hC8, 8'hEB, 8'hBB, 8'h3C, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2B, 8'h04, 8'h7E, 8'hBA, 8'h77, 8'hD6, 8'h26,
    8'hE1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0C, 8'h7D
  };

endpackage

`default_nettype wire

[rtl/core/sbpr_datapath.sv]
// Datapath: generator registers, round logic, rejection test and output register.
`timescale 1ns / 1ps
`default_nettype none

module sbpr_datapath
  import sbpr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_status_t               status,
  input  wire logic [BYTE_W-1:0]   seed_a,
  input  wire logic [BYTE_W-1:0]   seed_b,
  input  wire logic [BYTE_W-1:0]   seed_c,
  input  wire logic [WORD_W-1:0]   upper_bound,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [WORD_W-1:0]        value
);

  logic [BYTE_W-1:0]    mix_a;
  logic [BYTE_W-1:0]    mix_b;
  logic [BYTE_W-1:0]    mix_c;
  logic [BYTE_W-1:0]    round_counter;
  logic [WORD_W-1:0]    reject_mask;
  logic [ATTEMPT_W-1:0] attempts;

  logic [BYTE_W-1:0]    seed_a_q;
  logic [BYTE_W-1:0]    seed_b_q;
  logic [BYTE_W-1:0]    seed_c_q;
  logic [WORD_W-1:0]    bound_q;
  logic [BYTE_W-1:0]    lo_q;
  logic [WORD_W-1:0]    word_q;
  logic [WORD_W-1:0]    hold_q;
  logic [WORD_W-1:0]    result_q;

  logic [BYTE_W-1:0]    src_a;
  logic [BYTE_W-1:0]    src_b;
  logic [BYTE_W-1:0]    src_c;
  logic [BYTE_W-1:0]    counter_next;
  logic [BYTE_W-1:0]    a_next;
  logic [BYTE_W-1:0]    b_next;
  logic [BYTE_W-1:0]    mixer;
  logic [BYTE_W-1:0]    c_next;
  logic [WORD_W-1:0]    masked;
  logic                 in_range;
  logic                 last_try;
  logic [WORD_W-1:0]    half_mask;

  // One generator round; a reseed folds the entropy in first and uses b >> 1.
  always_comb begin
    src_a        = cmd.reseed ? (mix_a ^ seed_a_q) : mix_a;
    src_b        = cmd.reseed ? (mix_b ^ seed_b_q) : mix_b;
    src_c        = cmd.reseed ? (mix_c ^ seed_c_q) : mix_c;
    counter_next = round_counter + 8'd1;
    a_next       = src_a ^ src_c ^ counter_next;
    b_next       = src_b + a_next;
    mixer        = cmd.reseed ? (b_next >> 1) : INV_SBOX[b_next];
    c_next       = (src_c + mixer) ^ a_next;
  end

  always_comb begin
    masked    = word_q & reject_mask;
    in_range  = (masked <= bound_q);
    last_try  = (attempts == ATTEMPT_W'(MAX_ATTEMPTS - 1));
    half_mask = reject_mask >> 1;
  end

  assign status.hit      = in_range || last_try;
  assign status.out_busy = out_valid && !out_ready;
  assign value           = result_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_a         <= '0;
      mix_b         <= '0;
      mix_c         <= '0;
      round_counter <= '0;
      reject_mask   <= MASK_INIT;
      attempts      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.round || cmd.reseed) begin
        mix_a         <= a_next;
        mix_b         <= b_next;
        mix_c         <= c_next;
        round_counter <= counter_next;
      end
      if (cmd.start_bounded) begin
        reject_mask <= MASK_INIT;
        attempts    <= '0;
      end else if (cmd.check && !status.hit) begin
        if (half_mask >= bound_q) begin
          reject_mask <= half_mask;
        end
        attempts <= attempts + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the inputs and the word halves, and hold a finished result until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seed_a_q <= seed_a;
      seed_b_q <= seed_b;
      seed_c_q <= seed_c;
      bound_q  <= upper_bound;
    end
    if (cmd.take_lo) begin
      lo_q <= c_next;
    end
    if (cmd.take_hi) begin
      word_q <= {c_next, lo_q};
    end
    if (cmd.take_byte) begin
      hold_q <= {{(WORD_W-BYTE_W){1'b0}}, c_next};
    end else if (cmd.check && status.hit) begin
      hold_q <= in_range ? masked : bound_q;
    end
    if (cmd.emit) begin
      result_q <= hold_q;
    end
  end

  a_mask_covers_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.check |-> reject_mask >= bound_q)
    else $error("rejection mask fell below the bound");

  a_result_in_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.check && status.hit |=> hold_q <= bound_q)
    else $error("bounded result exceeds the bound");

endmodule

`default_nettype wire

[rtl/core/sbpr_ctrl.sv]
// Controller: sequences reseed, byte and bounded commands over the datapath.
`timescale 1ns / 1ps
`default_nettype none

module sbpr_ctrl
  import sbpr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] command,
  output dp_cmd_t               cmd,
  input  wire dp_status_t       status
);

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (command)
            CMD_RESEED: state_next = ST_RESEED;
            CMD_BYTE:   state_next = ST_BYTE;
            CMD_BOUNDED: begin
              cmd.start_bounded = 1'b1;
              state_next        = ST_LO;
            end
            default: state_next = ST_IDLE; // drop the unused code
          endcase
        end
      end
      ST_RESEED: begin
        cmd.reseed = 1'b1;
        state_next = ST_IDLE;
      end
      ST_BYTE: begin
        cmd.round     = 1'b1;
        cmd.take_byte = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_LO: begin
        cmd.round   = 1'b1;
        cmd.take_lo = 1'b1;
        state_next  = ST_HI;
      end
      ST_HI: begin
        cmd.round   = 1'b1;
        cmd.take_hi = 1'b1;
        state_next  = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = status.hit ? ST_EMIT : ST_LO;
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_retry_after_miss: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK && !status.hit |=> state == ST_LO)
    else $error("missed word did not start a new attempt");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy)
    else $error("result overwrote an untaken output");

  a_load_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> in_valid && state == ST_IDLE)
    else $error("input latched outside an accepted transaction");

endmodule

`default_nettype wire

[rtl/core/sbox_prng_bounded_rejection.sv]
// Top level of the S-box random generator with bounded rejection sampling.
// Input channel (in_valid/in_ready) carries one command transaction: command,
// seed_a..seed_c and upper_bound. Command 0 reseeds and gives no result,
// command 1 gives one random byte in value[7:0], command 2 gives a value in
// 0..upper_bound, and the unused code is dropped while the controller stays idle.
// Output channel (out_valid/out_ready) carries value through a single output
// register, so the next command is accepted while a result still waits.
// Each round passes through the inverse S-box table, except the reseed round,
// which uses b >> 1 instead. Steps of each command:
//   reseed  - accept, then the reseed round
//   byte    - accept, one round, then the emit step into the output register
//   bounded - accept, N attempts and the emit step; each attempt runs the
//             low-byte round, the high-byte round and a mask/compare step. N is capped at 1024.
// One command is worked at a time; in_ready is high only while the
// controller waits for a command.
// Reset (rst, synchronous) clears the mixing registers and the round counter,
// restores the rejection mask to all ones and empties the output register.
// When the receiver stalls, hold the result in the output register; a second
// result waits in a holding register while the controller stays in its emit
// step until the output register frees, and no new command is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module sbox_prng_bounded_rejection
  import sbpr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [BYTE_W-1:0] seed_a,
  input  wire logic [BYTE_W-1:0] seed_b,
  input  wire logic [BYTE_W-1:0] seed_c,
  input  wire logic [WORD_W-1:0] upper_bound,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      value
);

  // Commands from the controller, status back from the datapath.
  dp_cmd_t    cmd;
  dp_status_t status;

  sbpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .cmd      (cmd),
    .status   (status)
  );

  sbpr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .seed_a      (seed_a),
    .seed_b      (seed_b),
    .seed_c      (seed_c),
    .upper_bound (upper_bound),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .value       (value)
  );

endmodule

`default_nettype wire
